/* src/grace_period_reclaim_table_unit_macros.svh */
// Assertion macros for the grace period reclaim table unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GRACE_PERIOD_RECLAIM_TABLE_UNIT_MACROS_SVH
`define GRACE_PERIOD_RECLAIM_TABLE_UNIT_MACROS_SVH
`define GPRT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gprt assertion failed");
`define GPRT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gprt assertion failed");
`endif

/* src/gprt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the grace period reclaim table unit.
// No dependencies.
package gprt_pkg;

    localparam logic [2:0] K_INSERT   = 3'd0;
    localparam logic [2:0] K_DELETE   = 3'd1;
    localparam logic [2:0] K_READ     = 3'd2;
    localparam logic [2:0] K_QUIESCE  = 3'd3;
    localparam logic [2:0] K_CALLBACK = 3'd4;
    localparam logic [2:0] K_TICK     = 3'd5;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BADCPU   = 3'd4;
    localparam logic [2:0] ST_QFULL    = 3'd5;
    localparam logic [2:0] ST_NOADV    = 3'd6;

    localparam logic [2:0] CPU_COUNT_RESET = 3'd4;

    typedef struct packed {
        logic        active;
        logic        deleted;
    } flags_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] lookup_key;
        logic [31:0]        data_word;
        logic [2:0]         cpu_index;
        logic [31:0]        callback_handle;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_word;
        logic        is_callback;
        logic [2:0]  fired_cpu;
        logic [31:0] fired_handle;
        logic [10:0] freed_count;
        logic [31:0] grace_number;
        logic        last;
    } rsp_t;

endpackage

/* src/gprt_entry_mem.sv */
`timescale 1ns / 1ps
// Entry storage: flag memory and key/word memory, one read and one write port each.
// Depends on gprt_pkg.
module gprt_entry_mem #(
    parameter int ENTRIES = 1024,
    parameter int AW      = 10
) (
    input  logic                  clk,
    input  logic [AW-1:0]         rd_addr,
    output gprt_pkg::flags_t      rd_flags,
    output logic [31:0]           rd_key,
    output logic [31:0]           rd_word,
    input  logic                  flag_we,
    input  logic [AW-1:0]         flag_addr,
    input  gprt_pkg::flags_t      flag_data,
    input  logic                  kv_we,
    input  logic [AW-1:0]         kv_addr,
    input  logic [31:0]           kv_key,
    input  logic [31:0]           kv_word
);

    gprt_pkg::flags_t flag_mem [ENTRIES];
    logic [63:0]      kv_mem   [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_addr] <= flag_data;
        end
        rd_flags <= flag_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (kv_we)
        begin
            kv_mem[kv_addr] <= {kv_key, kv_word};
        end
        {rd_key, rd_word} <= kv_mem[rd_addr];
    end

endmodule

/* src/grace_period_reclaim_table_unit.sv */
`timescale 1ns / 1ps
// Insert, delete, read: one entry per cycle table scan, then the result. Report, register
// and unadvanced tick: result with no table scan. Advancing tick: each queued callback is
// put out in turn (output stalls hold it), then a scan frees deleted entries, then a summary.
// One request at a time; the next is taken once the last result is in the output register,
// output stalls delay that. Async active-low reset, then a clearing pass over the table
// before the first request. Depends on gprt_pkg, gprt_entry_mem and the macros header.
module grace_period_reclaim_table_unit #(
    parameter int NUM_CPUS      = 4,
    parameter int TABLE_ENTRIES = 1024,
    parameter int QUEUE_DEPTH   = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_wr_data,
    input  logic           in_valid,
    output logic           in_stall,
    input  gprt_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output gprt_pkg::rsp_t out_data
);

    `include "grace_period_reclaim_table_unit_macros.svh"

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int SW  = AW + 1;
    localparam int CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CCW = $clog2(NUM_CPUS + 1);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QN  = NUM_CPUS * QUEUE_DEPTH;
    localparam int QAW = (QN > 1) ? $clog2(QN) : 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DR_CHK = 4'd3;
    localparam logic [3:0] S_DR_OUT = 4'd4;
    localparam logic [3:0] S_FIN    = 4'd5;

    logic [3:0]     state_reg, state_next;
    logic [2:0]     op_reg, op_next;
    logic [31:0]    key_reg, key_next;
    logic [31:0]    data_reg, data_next;
    logic [31:0]    grace_reg, grace_next;
    logic [2:0]     cpu_count_reg;
    logic [31:0]    lastq_reg [NUM_CPUS];
    logic [31:0]    lastq_next [NUM_CPUS];
    logic [FW-1:0]  fill_reg [NUM_CPUS];
    logic [FW-1:0]  fill_next [NUM_CPUS];
    logic [SW-1:0]  scan_reg, scan_next;
    logic           pv_reg, pv_next;
    logic [AW-1:0]  pidx_reg, pidx_next;
    logic           hit_reg, hit_next;
    logic [AW-1:0]  hidx_reg, hidx_next;
    logic [31:0]    hword_reg, hword_next;
    logic           free_reg, free_next;
    logic [AW-1:0]  fidx_reg, fidx_next;
    logic [10:0]    freed_reg, freed_next;
    logic [2:0]     status_reg, status_next;
    logic [31:0]    word_reg, word_next;
    logic [CCW-1:0] c_reg, c_next;
    logic [FW-1:0]  q_reg, q_next;
    logic           out_valid_reg, out_valid_next;
    gprt_pkg::rsp_t out_reg, out_next;

    gprt_pkg::flags_t rd_flags;
    logic [31:0]      rd_key, rd_word;
    logic             flag_we, kv_we;
    logic [AW-1:0]    flag_addr;
    gprt_pkg::flags_t flag_data;

    logic [31:0]      qmem [QN];
    logic [31:0]      qrd_reg;
    logic             q_we;
    logic [QAW-1:0]   q_waddr, q_raddr;

    logic [3:0]       eff_cpus;
    logic             bad_cpu;
    logic             adv;
    logic             out_free;
    logic [CW-1:0]    in_cidx;
    logic [CW-1:0]    dr_cidx;

    gprt_entry_mem #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_entry_mem (
        .clk       (clk),
        .rd_addr   (scan_reg[AW-1:0]),
        .rd_flags  (rd_flags),
        .rd_key    (rd_key),
        .rd_word   (rd_word),
        .flag_we   (flag_we),
        .flag_addr (flag_addr),
        .flag_data (flag_data),
        .kv_we     (kv_we),
        .kv_addr   (fidx_reg),
        .kv_key    (key_reg),
        .kv_word   (data_reg)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign eff_cpus = ({1'b0, cpu_count_reg} > 4'(NUM_CPUS)) ? 4'(NUM_CPUS)
                                                             : {1'b0, cpu_count_reg};
    assign bad_cpu  = ({1'b0, in_data.cpu_index} >= eff_cpus);
    assign in_cidx  = in_data.cpu_index[CW-1:0];
    assign dr_cidx  = c_reg[CW-1:0];
    assign q_waddr  = QAW'(in_cidx) * QAW'(QUEUE_DEPTH) + QAW'(fill_reg[in_cidx]);
    assign q_raddr  = QAW'(dr_cidx) * QAW'(QUEUE_DEPTH) + QAW'(q_reg);

    always_comb
    begin
        adv = 1'b1;
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            if ((4'(i) < eff_cpus) && (lastq_reg[i] < grace_reg))
            begin
                adv = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[q_waddr] <= in_data.callback_handle;
        end
        qrd_reg <= qmem[q_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        data_next      = data_reg;
        grace_next     = grace_reg;
        lastq_next     = lastq_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        pv_next        = 1'b0;
        pidx_next      = scan_reg[AW-1:0];
        hit_next       = hit_reg;
        hidx_next      = hidx_reg;
        hword_next     = hword_reg;
        free_next      = free_reg;
        fidx_next      = fidx_reg;
        freed_next     = freed_reg;
        status_next    = status_reg;
        word_next      = word_reg;
        c_next         = c_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        flag_we        = 1'b0;
        flag_addr      = pidx_reg;
        flag_data      = '0;
        kv_we          = 1'b0;
        q_we           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_data.kind;
                    key_next    = in_data.lookup_key;
                    data_next   = in_data.data_word;
                    word_next   = '0;
                    freed_next  = '0;
                    status_next = gprt_pkg::ST_DONE;
                    state_next  = S_FIN;
                    case (in_data.kind)
                        gprt_pkg::K_INSERT, gprt_pkg::K_DELETE, gprt_pkg::K_READ:
                        begin
                            scan_next  = '0;
                            hit_next   = 1'b0;
                            free_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        gprt_pkg::K_QUIESCE:
                        begin
                            if (bad_cpu)
                            begin
                                status_next = gprt_pkg::ST_BADCPU;
                            end
                            else
                            begin
                                lastq_next[in_cidx] = grace_reg;
                            end
                        end
                        gprt_pkg::K_CALLBACK:
                        begin
                            if (bad_cpu)
                            begin
                                status_next = gprt_pkg::ST_BADCPU;
                            end
                            else if (fill_reg[in_cidx] >= FW'(QUEUE_DEPTH))
                            begin
                                status_next = gprt_pkg::ST_QFULL;
                            end
                            else
                            begin
                                q_we               = 1'b1;
                                fill_next[in_cidx] = fill_reg[in_cidx] + FW'(1);
                            end
                        end
                        gprt_pkg::K_TICK:
                        begin
                            if (!adv)
                            begin
                                status_next = gprt_pkg::ST_NOADV;
                            end
                            else
                            begin
                                if (grace_reg != '1)
                                begin
                                    grace_next = grace_reg + 32'd1;
                                end
                                c_next     = '0;
                                q_next     = '0;
                                state_next = S_DR_CHK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                flag_we   = 1'b1;
                flag_addr = scan_reg[AW-1:0];
                scan_next = scan_reg + SW'(1);
                if (scan_reg == SW'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (scan_reg < SW'(TABLE_ENTRIES))
                begin
                    pv_next   = 1'b1;
                    scan_next = scan_reg + SW'(1);
                end
                if (pv_reg)
                begin
                    case (op_reg)
                        gprt_pkg::K_INSERT:
                        begin
                            if (rd_flags.active && rd_key == key_reg)
                            begin
                                hit_next = 1'b1;
                            end
                            if (!rd_flags.active && !rd_flags.deleted && !free_reg)
                            begin
                                free_next = 1'b1;
                                fidx_next = pidx_reg;
                            end
                        end
                        gprt_pkg::K_DELETE, gprt_pkg::K_READ:
                        begin
                            if (rd_flags.active && rd_key == key_reg && !hit_reg)
                            begin
                                hit_next   = 1'b1;
                                hidx_next  = pidx_reg;
                                hword_next = rd_word;
                            end
                        end
                        default:
                        begin
                            if (rd_flags.deleted)
                            begin
                                flag_we           = 1'b1;
                                flag_data.active  = rd_flags.active;
                                flag_data.deleted = 1'b0;
                                if (freed_reg != '1)
                                begin
                                    freed_next = freed_reg + 11'd1;
                                end
                            end
                        end
                    endcase
                end
                else if (scan_reg == SW'(TABLE_ENTRIES))
                begin
                    state_next = S_FIN;
                    case (op_reg)
                        gprt_pkg::K_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                status_next = gprt_pkg::ST_DUP;
                            end
                            else if (!free_reg)
                            begin
                                status_next = gprt_pkg::ST_FULL;
                            end
                            else
                            begin
                                flag_we          = 1'b1;
                                flag_addr        = fidx_reg;
                                flag_data.active = 1'b1;
                                kv_we            = 1'b1;
                            end
                        end
                        gprt_pkg::K_DELETE:
                        begin
                            if (!hit_reg)
                            begin
                                status_next = gprt_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                flag_we           = 1'b1;
                                flag_addr         = hidx_reg;
                                flag_data.deleted = 1'b1;
                            end
                        end
                        gprt_pkg::K_READ:
                        begin
                            if (!hit_reg)
                            begin
                                status_next = gprt_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                word_next = hword_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DR_CHK:
            begin
                if (c_reg == CCW'(NUM_CPUS))
                begin
                    scan_next  = '0;
                    state_next = S_SCAN;
                end
                else if (q_reg < fill_reg[dr_cidx])
                begin
                    state_next = S_DR_OUT;
                end
                else
                begin
                    fill_next[dr_cidx] = '0;
                    c_next             = c_reg + CCW'(1);
                    q_next             = '0;
                end
            end
            S_DR_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.status      = gprt_pkg::ST_DONE;
                    out_next.is_callback = 1'b1;
                    out_next.fired_cpu   = 3'(c_reg);
                    out_next.fired_handle = qrd_reg;
                    out_next.grace_number = grace_reg;
                    q_next               = q_reg + FW'(1);
                    state_next           = S_DR_CHK;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.status       = status_reg;
                    out_next.read_word    = word_reg;
                    out_next.freed_count  = freed_reg;
                    out_next.grace_number = grace_reg;
                    out_next.last         = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_reg      <= '0;
            pv_reg        <= 1'b0;
            grace_reg     <= '0;
            cpu_count_reg <= gprt_pkg::CPU_COUNT_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                lastq_reg[i] <= '0;
                fill_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            pv_reg        <= pv_next;
            grace_reg     <= grace_next;
            out_valid_reg <= out_valid_next;
            lastq_reg     <= lastq_next;
            fill_reg      <= fill_next;
            if (cfg_wr_en)
            begin
                cpu_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        data_reg   <= data_next;
        pidx_reg   <= pidx_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        hword_reg  <= hword_next;
        free_reg   <= free_next;
        fidx_reg   <= fidx_next;
        freed_reg  <= freed_next;
        status_reg <= status_next;
        word_reg   <= word_next;
        c_reg      <= c_next;
        q_reg      <= q_next;
        out_reg    <= out_next;
    end

    `GPRT_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall)
    `GPRT_ASSERT_IMP(a_cb_not_last, out_valid && out_data.is_callback, !out_data.last)
    `GPRT_ASSERT_IMP(a_freed_in_summary, out_valid && out_data.freed_count != 11'd0,
                     out_data.last && out_data.status == gprt_pkg::ST_DONE)

endmodule

/* bench/tb_grace_period_reclaim_table_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for grace_period_reclaim_table_unit: directed and random
// requests, checked against an in-bench model of the table, queues and grace counter.
// Depends on gprt_pkg and the RTL of the unit.
module tb_grace_period_reclaim_table_unit;

    localparam int NCPU      = 4;
    localparam int NENT      = 1024;
    localparam int QDEPTH    = 8;
    localparam int IDLE_LIMIT = 20000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_wr_en = 1'b0;
    logic [2:0]     cfg_wr_data = 3'd0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    gprt_pkg::req_t in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    gprt_pkg::rsp_t out_data;

    grace_period_reclaim_table_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    always #5 clk = ~clk;

    // table model
    logic [2:0]  cpu_count_m;
    logic [31:0] grace_m;
    bit          ent_active [NENT];
    bit          ent_deleted [NENT];
    logic [31:0] ent_key [NENT];
    logic [31:0] ent_word [NENT];
    logic [31:0] cpu_quiesced [NCPU];
    logic [31:0] cb_handles [NCPU][QDEPTH];
    int          cb_fill [NCPU];

    gprt_pkg::rsp_t expected_rsps [$];
    int          errors;
    int          requests_sent;
    int          rsps_checked;
    int          advances;
    int          callbacks_fired;
    int          hold_len;
    bit          quiet;
    int          idle_cycles;
    logic [31:0] key_pool [8];

    function automatic int find_key(logic [31:0] key);
        for (int i = 0; i < NENT; i++)
            if (ent_active[i] && ent_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic gprt_pkg::rsp_t mk_rsp(logic [2:0] st);
        gprt_pkg::rsp_t r;
        r = '0;
        r.status = st;
        r.grace_number = grace_m;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic apply_request(gprt_pkg::req_t r);
        int             idx;
        int             ncpu;
        int             freed;
        gprt_pkg::rsp_t e;
        logic [31:0]    key;
        key = r.lookup_key;
        ncpu = (cpu_count_m > NCPU) ? NCPU : cpu_count_m;
        case (r.kind)
            gprt_pkg::K_INSERT: begin
                if (find_key(key) >= 0)
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_DUP));
                else begin
                    idx = -1;
                    for (int i = 0; i < NENT && idx < 0; i++)
                        if (!ent_active[i] && !ent_deleted[i])
                            idx = i;
                    if (idx < 0)
                        expected_rsps.push_back(mk_rsp(gprt_pkg::ST_FULL));
                    else begin
                        ent_active[idx] = 1;
                        ent_key[idx] = key;
                        ent_word[idx] = r.data_word;
                        expected_rsps.push_back(mk_rsp(gprt_pkg::ST_DONE));
                    end
                end
            end
            gprt_pkg::K_DELETE: begin
                idx = find_key(key);
                if (idx < 0)
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_NOTFOUND));
                else begin
                    ent_active[idx] = 0;
                    ent_deleted[idx] = 1;
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_DONE));
                end
            end
            gprt_pkg::K_READ: begin
                idx = find_key(key);
                if (idx < 0)
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_NOTFOUND));
                else begin
                    e = mk_rsp(gprt_pkg::ST_DONE);
                    e.read_word = ent_word[idx];
                    expected_rsps.push_back(e);
                end
            end
            gprt_pkg::K_QUIESCE: begin
                if (r.cpu_index >= ncpu)
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_BADCPU));
                else begin
                    cpu_quiesced[r.cpu_index] = grace_m;
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_DONE));
                end
            end
            gprt_pkg::K_CALLBACK: begin
                if (r.cpu_index >= ncpu)
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_BADCPU));
                else if (cb_fill[r.cpu_index] >= QDEPTH)
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_QFULL));
                else begin
                    cb_handles[r.cpu_index][cb_fill[r.cpu_index]] = r.callback_handle;
                    cb_fill[r.cpu_index]++;
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_DONE));
                end
            end
            gprt_pkg::K_TICK: begin
                idx = 0;
                for (int c = 0; c < ncpu; c++)
                    if (cpu_quiesced[c] < grace_m)
                        idx = 1;
                if (idx)
                    expected_rsps.push_back(mk_rsp(gprt_pkg::ST_NOADV));
                else begin
                    advances++;
                    if (grace_m != 32'hFFFF_FFFF)
                        grace_m++;
                    for (int c = 0; c < NCPU; c++) begin
                        for (int q = 0; q < cb_fill[c]; q++) begin
                            e = mk_rsp(gprt_pkg::ST_DONE);
                            e.is_callback = 1'b1;
                            e.fired_cpu = c[2:0];
                            e.fired_handle = cb_handles[c][q];
                            e.last = 1'b0;
                            expected_rsps.push_back(e);
                            callbacks_fired++;
                        end
                        cb_fill[c] = 0;
                    end
                    freed = 0;
                    for (int i = 0; i < NENT; i++)
                        if (ent_deleted[i]) begin
                            ent_deleted[i] = 0;
                            freed++;
                        end
                    e = mk_rsp(gprt_pkg::ST_DONE);
                    e.freed_count = (freed > 2047) ? 11'd2047 : freed[10:0];
                    expected_rsps.push_back(e);
                end
            end
            default: expected_rsps.push_back(mk_rsp(gprt_pkg::ST_DONE));
        endcase
    endtask

    function automatic int pick_gap();
        if (quiet)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(0, 2);
    endfunction

    // one request through the handshake, model updated on acceptance
    task automatic send(gprt_pkg::req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
        apply_request(r);
    endtask

    function automatic gprt_pkg::req_t mk_req(logic [2:0] k, logic [31:0] key,
                                              logic [31:0] data, logic [2:0] cpu,
                                              logic [31:0] handle);
        gprt_pkg::req_t r;
        r.kind = k;
        r.lookup_key = key;
        r.data_word = data;
        r.cpu_index = cpu;
        r.callback_handle = handle;
        return r;
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cpu_count(logic [2:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cpu_count_m = v;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic quiesce_all();
        for (int c = 0; c < NCPU; c++)
            send(mk_req(gprt_pkg::K_QUIESCE, $urandom, $urandom, c[2:0], $urandom));
    endtask

    task automatic test_basic_ops();
        send(mk_req(gprt_pkg::K_TICK, 0, 0, 0, 0));
        send(mk_req(gprt_pkg::K_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF));
        send(mk_req(gprt_pkg::K_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 3'd0, 32'h0));
        send(mk_req(gprt_pkg::K_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 3'd0, 32'h0));
        send(mk_req(gprt_pkg::K_INSERT, 32'h8000_0000, 32'h1234_5678, 3'd0, 32'h0));
        send(mk_req(gprt_pkg::K_READ, 32'h8000_0000, 0, 0, 0));
        send(mk_req(gprt_pkg::K_READ, 32'hFFFF_FFFF, 0, 0, 0));
        send(mk_req(gprt_pkg::K_READ, 32'h0000_0000, 0, 0, 0));
        send(mk_req(gprt_pkg::K_DELETE, 32'h7FFF_FFFF, 0, 0, 0));
        send(mk_req(gprt_pkg::K_DELETE, 32'h7FFF_FFFF, 0, 0, 0));
        send(mk_req(gprt_pkg::K_READ, 32'h7FFF_FFFF, 0, 0, 0));
        send(mk_req(gprt_pkg::K_QUIESCE, 0, 0, 3'd7, 0));
        send(mk_req(gprt_pkg::K_CALLBACK, 0, 0, 3'd4, 32'hDEAD_BEEF));
        send(mk_req(gprt_pkg::K_CALLBACK, 0, 0, 3'd3, 32'hFFFF_FFFF));
        send(mk_req(gprt_pkg::K_CALLBACK, 0, 0, 3'd0, 32'h0000_0000));
        send(mk_req(gprt_pkg::K_TICK, 0, 0, 0, 0));
        quiesce_all();
        send(mk_req(gprt_pkg::K_TICK, 0, 0, 0, 0));
        send(mk_req(3'd6, 32'h1, 32'h2, 3'd1, 32'h3));
        send(mk_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF));
        send(mk_req(gprt_pkg::K_INSERT, 32'h7FFF_FFFF, 32'h0BAD_F00D, 0, 0));
    endtask

    task automatic test_queue_full();
        for (int i = 0; i < QDEPTH + 1; i++)
            send(mk_req(gprt_pkg::K_CALLBACK, 0, 0, 3'd1, 32'h100 + i));
        send(mk_req(gprt_pkg::K_CALLBACK, 0, 0, 3'd2, 32'hCAFE_0002));
        quiesce_all();
        send(mk_req(gprt_pkg::K_TICK, 0, 0, 0, 0));
    endtask

    task automatic test_cpu_count();
        write_cpu_count(3'd0);
        send(mk_req(gprt_pkg::K_QUIESCE, 0, 0, 3'd0, 0));
        send(mk_req(gprt_pkg::K_CALLBACK, 0, 0, 3'd0, 32'h55));
        send(mk_req(gprt_pkg::K_TICK, 0, 0, 0, 0));
        send(mk_req(gprt_pkg::K_TICK, 0, 0, 0, 0));
        write_cpu_count(3'd7);
        send(mk_req(gprt_pkg::K_QUIESCE, 0, 0, 3'd4, 0));
        send(mk_req(gprt_pkg::K_CALLBACK, 0, 0, 3'd3, 32'h77));
        send(mk_req(gprt_pkg::K_TICK, 0, 0, 0, 0));
        quiesce_all();
        send(mk_req(gprt_pkg::K_TICK, 0, 0, 0, 0));
        write_cpu_count(3'd1);
        send(mk_req(gprt_pkg::K_CALLBACK, 0, 0, 3'd1, 32'h11));
        send(mk_req(gprt_pkg::K_CALLBACK, 0, 0, 3'd0, 32'h10));
        send(mk_req(gprt_pkg::K_QUIESCE, 0, 0, 3'd0, 0));
        send(mk_req(gprt_pkg::K_TICK, 0, 0, 0, 0));
        write_cpu_count(3'd2);
    endtask

    task automatic test_backpressure();
        wait_idle();
        quiet = 1;
        hold_len = 400;
        for (int i = 0; i < 5; i++)
            send(mk_req(gprt_pkg::K_QUIESCE, 0, 0, i[2:0], 0));
        quiet = 0;
        wait_idle();
    endtask

    task automatic test_random(int n);
        gprt_pkg::req_t r;
        logic [31:0]    key;
        int             sel;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2)
                write_cpu_count(3'd4);
            key = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
            sel = $urandom_range(0, 99);
            if (sel < 20)
                r = mk_req(gprt_pkg::K_INSERT, key, $urandom, 3'($urandom), $urandom);
            else if (sel < 35)
                r = mk_req(gprt_pkg::K_DELETE, key, $urandom, 3'($urandom), $urandom);
            else if (sel < 50)
                r = mk_req(gprt_pkg::K_READ, key, $urandom, 3'($urandom), $urandom);
            else if (sel < 70)
                r = mk_req(gprt_pkg::K_QUIESCE, $urandom, $urandom,
                           3'($urandom_range(0, 4)), $urandom);
            else if (sel < 82)
                r = mk_req(gprt_pkg::K_CALLBACK, $urandom, $urandom,
                           3'($urandom_range(0, 4)), $urandom);
            else if (sel < 95)
                r = mk_req(gprt_pkg::K_TICK, $urandom, $urandom, 3'($urandom), $urandom);
            else
                r = mk_req(3'($urandom_range(6, 7)), $urandom, $urandom,
                           3'($urandom), $urandom);
            send(r);
        end
    endtask

    // receiver side: random stall, with an occasional long hold-off
    initial begin
        forever begin
            @(posedge clk);
            if (hold_len > 0) begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
                out_stall <= 1'b0;
            end else if (quiet)
                out_stall <= 1'b0;
            else if ($urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 3))
                    @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            rsps_checked++;
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end else begin
                if (out_data !== expected_rsps[0]) begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             expected_rsps[0], out_data);
                    errors++;
                end
                void'(expected_rsps.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("grace_period_reclaim_table_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        requests_sent = 0;
        rsps_checked = 0;
        advances = 0;
        callbacks_fired = 0;
        hold_len = 0;
        quiet = 0;
        idle_cycles = 0;
        cpu_count_m = gprt_pkg::CPU_COUNT_RESET;
        grace_m = '0;
        for (int i = 0; i < NENT; i++) begin
            ent_active[i] = 0;
            ent_deleted[i] = 0;
        end
        for (int c = 0; c < NCPU; c++) begin
            cpu_quiesced[c] = '0;
            cb_fill[c] = 0;
        end
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++)
            key_pool[i] = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_queue_full();
        test_cpu_count();
        test_backpressure();
        test_random(40);

        wait_idle();
        repeat (50) @(posedge clk);
        $display("Covered %0d requests, %0d results, %0d grace advances, %0d callbacks,",
                 requests_sent, rsps_checked, advances, callbacks_fired);
        $display("cpu counts 0/1/2/4/7, full queue, unknown kinds and a long output hold-off.");
        if (errors == 0 && expected_rsps.size() == 0)
            $display("grace_period_reclaim_table_unit test passed");
        else
            $display("grace_period_reclaim_table_unit test failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/gprt_pkg.sv
src/gprt_entry_mem.sv
src/grace_period_reclaim_table_unit.sv
bench/tb_grace_period_reclaim_table_unit.sv
